// ===== rtl/mfps_pkg.sv =====
`default_nettype none
package mfps_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_WIDTH_W = 9;
	localparam int VALUE_W = 16;
	localparam int SUM_W = 32;
	// counter compare width: holds MAX_COLUMNS and any row_width value
	localparam int CNT_W = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic [COL_W-1:0]          col;
		logic                      first_row;
		logic                      row_end;
	} entry_t;

endpackage
`default_nettype wire

// ===== rtl/mfps_front.sv =====
`default_nettype none
module mfps_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [mfps_pkg::ROW_WIDTH_W-1:0] cfg_wr_data,
	input  wire logic                             push,
	input  wire logic signed [mfps_pkg::VALUE_W-1:0] value,
	input  wire logic                             last,
	output mfps_pkg::entry_t                      entry
);
	import mfps_pkg::*;

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [COL_W-1:0]       col_q;
	logic                   first_row_q;
	logic [CNT_W-1:0]       width_ext;
	logic [CNT_W-1:0]       eff_width;
	logic [CNT_W-1:0]       col_next;
	logic                   row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_W'(1);
		end else if (cfg_wr_en) begin
			row_width_q <= cfg_wr_data;
		end
	end

	// zero acts as one, anything above the array size is clamped
	always_comb begin
		width_ext = CNT_W'(row_width_q);
		if (width_ext == '0) begin
			eff_width = CNT_W'(1);
		end else if (width_ext > CNT_W'(MAX_COLUMNS)) begin
			eff_width = CNT_W'(MAX_COLUMNS);
		end else begin
			eff_width = width_ext;
		end
		col_next = CNT_W'(col_q) + CNT_W'(1);
		row_end  = !last && (col_next >= eff_width);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (push) begin
			if (last) begin
				col_q       <= '0;
				first_row_q <= 1'b1;
			end else if (row_end) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	always_comb begin
		entry.value     = value;
		entry.last      = last;
		entry.col       = col_q;
		entry.first_row = first_row_q;
		entry.row_end   = row_end;
	end

endmodule
`default_nettype wire

// ===== rtl/mfps_queue.sv =====
`default_nettype none
module mfps_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mfps_pkg::entry_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output mfps_pkg::entry_t      pop_entry
);
	import mfps_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mfps_back.sv =====
`default_nettype none
module mfps_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire mfps_pkg::entry_t             q_entry,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [mfps_pkg::SUM_W-1:0] min_sum,
	output logic                              no_path
);
	import mfps_pkg::*;

	// inf set means no path reaches this sum
	typedef struct packed {
		logic                    inf;
		logic signed [SUM_W-1:0] val;
	} sum_t;

	localparam sum_t SUM_INF = '{inf: 1'b1, val: '0};

	function automatic logic sum_less(input sum_t a, input sum_t b);
		logic res;
		if (a.inf) begin
			res = 1'b0;
		end else if (b.inf) begin
			res = 1'b1;
		end else begin
			res = (a.val < b.val);
		end
		return res;
	endfunction

	sum_t             prev_best_q;
	logic [COL_W-1:0] prev_best_col_q;
	sum_t             prev_second_q;
	sum_t             cur_best_q;
	logic [COL_W-1:0] cur_best_col_q;
	sum_t             cur_second_q;

	logic                    out_valid_q;
	logic signed [SUM_W-1:0] min_sum_q;
	logic                    no_path_q;

	sum_t                    pred;
	sum_t                    path;
	logic signed [SUM_W:0]   sum_wide;
	sum_t                    nxt_best;
	logic [COL_W-1:0]        nxt_best_col;
	sum_t                    nxt_second;
	logic                    slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = q_valid && (!q_entry.last || slot_free);

	always_comb begin
		pred     = (q_entry.col != prev_best_col_q) ? prev_best_q : prev_second_q;
		sum_wide = {pred.val[SUM_W-1], pred.val} + (SUM_W + 1)'(q_entry.value);
		if (q_entry.first_row) begin
			path.inf = 1'b0;
			path.val = SUM_W'(q_entry.value);
		end else if (pred.inf) begin
			path = SUM_INF;
		end else begin
			path.inf = 1'b0;
			if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
				// saturate toward the sign of the true sum
				path.val = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
				                           : {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				path.val = sum_wide[SUM_W-1:0];
			end
		end

		nxt_best     = cur_best_q;
		nxt_best_col = cur_best_col_q;
		nxt_second   = cur_second_q;
		if (sum_less(path, cur_best_q)) begin
			nxt_second   = cur_best_q;
			nxt_best     = path;
			nxt_best_col = q_entry.col;
		end else if (sum_less(path, cur_second_q)) begin
			nxt_second = path;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_best_q     <= SUM_INF;
			prev_best_col_q <= '0;
			prev_second_q   <= SUM_INF;
			cur_best_q      <= SUM_INF;
			cur_best_col_q  <= '0;
			cur_second_q    <= SUM_INF;
		end else if (pop) begin
			if (q_entry.last) begin
				prev_best_q     <= SUM_INF;
				prev_best_col_q <= '0;
				prev_second_q   <= SUM_INF;
				cur_best_q      <= SUM_INF;
				cur_best_col_q  <= '0;
				cur_second_q    <= SUM_INF;
			end else if (q_entry.row_end) begin
				prev_best_q     <= nxt_best;
				prev_best_col_q <= nxt_best_col;
				prev_second_q   <= nxt_second;
				cur_best_q      <= SUM_INF;
				cur_best_col_q  <= '0;
				cur_second_q    <= SUM_INF;
			end else begin
				cur_best_q     <= nxt_best;
				cur_best_col_q <= nxt_best_col;
				cur_second_q   <= nxt_second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && q_entry.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_entry.last) begin
			no_path_q <= nxt_best.inf;
			min_sum_q <= nxt_best.inf ? '0 : nxt_best.val;
		end
	end

	assign out_valid = out_valid_q;
	assign min_sum   = min_sum_q;
	assign no_path   = no_path_q;

endmodule
`default_nettype wire

// ===== rtl/min_falling_path_sum_no_same_column_core.sv =====
`default_nettype none
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------
// cfg      | cfg_wr_en               | cfg_wr_data (row width)
// in       | in_valid / in_stall     | value, last
// out      | out_valid / out_stall   | min_sum, no_path
//
// One element per cycle while in_stall is low. An accepted element enters a
// 4-entry queue; the back end takes one entry a cycle unless a last entry waits
// on out_stall, and registers the result and out_valid when it takes the last.
// in_stall rises only when the queue is full; out_stall holds the result
// register and, once the queue fills, the input. No clearing pass after reset.
module min_falling_path_sum_no_same_column_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [mfps_pkg::ROW_WIDTH_W-1:0] cfg_wr_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [mfps_pkg::VALUE_W-1:0] value,
	input  wire logic                             last,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [mfps_pkg::SUM_W-1:0]     min_sum,
	output logic                                  no_path
);
	import mfps_pkg::*;

	entry_t push_entry;
	entry_t pop_entry;
	logic   push;
	logic   pop;
	logic   full;
	logic   not_empty;

	assign in_stall = full;
	assign push     = in_valid && !full;

	mfps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.value       (value),
		.last        (last),
		.entry       (push_entry)
	);

	mfps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.pop_entry  (pop_entry)
	);

	mfps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_entry   (pop_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.min_sum   (min_sum),
		.no_path   (no_path)
	);

endmodule
`default_nettype wire
